// File: rtl/core/gso3_pkg.sv
package gso3_pkg;

  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 32;
  localparam logic signed [31:0] OneQ30 = 32'sd1073741824;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic               degenerate;
  } out_word_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic signed [63:0] v);
    if (v > 64'sd1073741824) begin
      clamp_q30 = OneQ30;
    end else if (v < -64'sd1073741824) begin
      clamp_q30 = -OneQ30;
    end else begin
      clamp_q30 = v[31:0];
    end
  endfunction

  function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] q;
    m = v[63] ? (~v + 64'd1) : v;
    q = (m + 64'd536870912) >> 30;
    rnd30 = v[63] ? -$signed(q) : $signed(q);
  endfunction

endpackage

// File: rtl/core/gso3_stream_if.sv
interface gso3_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/gram_schmidt_orthogonalize_3d.sv
// channel | dir | payload
// in_s    | in  | a_x a_y a_z b_x b_y b_z, Q16.16
// out_m   | out | r_x r_y r_z Q1.30, degenerate
// One word per cycle while the output is not stalled; the depth is set by the sqrt and
// divide pipelines, one bit per stage.
// Reset clears the valid bits only.
// A stall at the output freezes the whole pipeline; nothing is lost.
module gram_schmidt_orthogonalize_3d (
  input logic clk_i,
  input logic rst_ni,
  gso3_stream_if.sink   in_s,
  gso3_stream_if.source out_m
);
  import gso3_pkg::*;

  localparam int unsigned UnitLat = 3 + 1 + SqrtSteps + 1 + DivSteps;
  localparam int unsigned Lat = UnitLat + 4;

  logic en;
  logic [Lat-1:0] vld_q;
  assign en = !vld_q[Lat-1] || out_m.ready;
  assign in_s.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_s.valid};
    end
  end

  logic signed [31:0] va [3], vb [3], ua [3], ub [3];
  logic za, zb;
  assign va = '{in_s.data.a_x, in_s.data.a_y, in_s.data.a_z};
  assign vb = '{in_s.data.b_x, in_s.data.b_y, in_s.data.b_z};

  gso3_unit u_a (.clk_i, .rst_ni, .en_i(en), .v_i(va), .u_o(ua), .zero_o(za));
  gso3_unit u_b (.clk_i, .rst_ni, .en_i(en), .v_i(vb), .u_o(ub), .zero_o(zb));

  // dot: products, then sum and round
  logic signed [63:0] p_q [3];
  logic signed [31:0] ua1_q [3], ub1_q [3], ua2_q [3], ub2_q [3];
  logic               dg1_q, dg2_q, dg3_q;
  logic signed [31:0] d_q;
  logic signed [63:0] pr_q [3];
  logic signed [31:0] ub3_q [3];
  out_word_t          o_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) p_q[i] <= ua[i] * ub[i];
      ua1_q <= ua; ub1_q <= ub; dg1_q <= za || zb;
      d_q <= clamp_q30(rnd30(p_q[0] + p_q[1] + p_q[2]));
      ua2_q <= ua1_q; ub2_q <= ub1_q; dg2_q <= dg1_q;
      for (int i = 0; i < 3; i++) pr_q[i] <= ua2_q[i] * d_q;
      ub3_q <= ub2_q; dg3_q <= dg2_q;
      o_q.r_x <= dg3_q ? '0 : clamp_q30(64'(ub3_q[0]) - rnd30(pr_q[0]));
      o_q.r_y <= dg3_q ? '0 : clamp_q30(64'(ub3_q[1]) - rnd30(pr_q[1]));
      o_q.r_z <= dg3_q ? '0 : clamp_q30(64'(ub3_q[2]) - rnd30(pr_q[2]));
      o_q.degenerate <= dg3_q;
    end
  end

  assign out_m.valid = vld_q[Lat-1];
  assign out_m.data  = o_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_m.valid && !out_m.ready |=> out_m.valid && $stable(out_m.data))
    else $error("output word changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_m.valid |-> in_s.ready)
    else $error("stalled with empty output");
  a_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_m.valid && out_m.data.degenerate |-> out_m.data.r_x == 0 &&
    out_m.data.r_y == 0 && out_m.data.r_z == 0)
    else $error("degenerate word not zero");
endmodule

// File: rtl/core/gso3_unit.sv
module gso3_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic signed [31:0] v_i [3],
  output logic signed [31:0] u_o [3],
  output logic               zero_o
);
  import gso3_pkg::*;

  // stage 0: magnitudes, max
  logic [31:0] m0_q [3];
  logic        n0_q [3];
  logic [31:0] mx0_q;
  logic [31:0] mx;
  always_comb begin
    mx = mag32(v_i[0]);
    if (mag32(v_i[1]) > mx) mx = mag32(v_i[1]);
    if (mag32(v_i[2]) > mx) mx = mag32(v_i[2]);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        m0_q[i] <= mag32(v_i[i]);
        n0_q[i] <= v_i[i][31];
      end
      mx0_q <= mx;
    end
  end

  // stage 1: leading-zero shift
  logic [31:0] m1_q [3];
  logic        n1_q [3];
  logic        z1_q;
  logic [4:0]  k;
  always_comb begin
    k = 5'd0;
    for (int j = 0; j < 30; j++) begin
      if (mx0_q[j]) k = 5'(30 - j);
    end
    if (mx0_q[31:30] != 2'b00) k = 5'd0;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) m1_q[i] <= m0_q[i] << k;
      n1_q <= n0_q;
      z1_q <= (mx0_q == '0);
    end
  end

  // stage 2: squares
  logic [63:0] sq2_q [3];
  logic [31:0] m2_q [3];
  logic        n2_q [3];
  logic        z2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) sq2_q[i] <= m1_q[i] * m1_q[i];
      m2_q <= m1_q; n2_q <= n1_q; z2_q <= z1_q;
    end
  end

  // stage 3: sum; sqrt pipeline of SqrtSteps stages, one result bit each
  logic [65:0] rem_q [SqrtSteps+1];
  logic [32:0] res_q [SqrtSteps+1];
  logic [31:0] ms_q  [SqrtSteps+1][3];
  logic        ns_q  [SqrtSteps+1][3];
  logic        zs_q  [SqrtSteps+1];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {2'b0, sq2_q[0]} + {2'b0, sq2_q[1]} + {2'b0, sq2_q[2]};
      res_q[0] <= '0;
      ms_q[0] <= m2_q; ns_q[0] <= n2_q; zs_q[0] <= z2_q;
    end
  end
  for (genvar s = 0; s < SqrtSteps; s++) begin : g_sqrt
    localparam int unsigned Sh = 2 * (SqrtSteps - 1 - s);
    logic [65:0] trial;
    assign trial = ({33'd0, res_q[s]} << (Sh + 2)) | (66'd1 << Sh);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_q[s] >= trial) begin
          rem_q[s+1] <= rem_q[s] - trial;
          res_q[s+1] <= {res_q[s][31:0], 1'b1};
        end else begin
          rem_q[s+1] <= rem_q[s];
          res_q[s+1] <= {res_q[s][31:0], 1'b0};
        end
        ms_q[s+1] <= ms_q[s]; ns_q[s+1] <= ns_q[s]; zs_q[s+1] <= zs_q[s];
      end
    end
  end

  // divide: q = (2*m*2^30 + s) / (2s), restoring, one quotient bit a stage
  logic [33:0] dd;
  assign dd = {res_q[SqrtSteps], 1'b0};
  logic [64:0] num0 [3];
  for (genvar i = 0; i < 3; i++) begin : g_num
    assign num0[i] = ({33'd0, ms_q[SqrtSteps][i]} << 31) + {32'd0, res_q[SqrtSteps]};
  end
  logic [33:0] drem_q [DivSteps+1][3];
  logic [64:0] dnum_q [DivSteps+1][3];
  logic [33:0] dv_q   [DivSteps+1];
  logic        dn_q   [DivSteps+1][3];
  logic        dz_q   [DivSteps+1];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        drem_q[0][i] <= {1'b0, num0[i][64:32]};
        dnum_q[0][i] <= {num0[i][31:0], 33'd0};
      end
      dv_q[0] <= dd; dn_q[0] <= ns_q[SqrtSteps]; dz_q[0] <= zs_q[SqrtSteps];
    end
  end
  for (genvar s = 0; s < DivSteps; s++) begin : g_div
    logic [34:0] t [3];
    for (genvar i = 0; i < 3; i++) begin : g_l
      assign t[i] = {drem_q[s][i], dnum_q[s][i][64]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          if (t[i] >= {1'b0, dv_q[s]}) begin
            drem_q[s+1][i] <= 34'(t[i] - {1'b0, dv_q[s]});
            dnum_q[s+1][i] <= {dnum_q[s][i][63:0], 1'b1};
          end else begin
            drem_q[s+1][i] <= t[i][33:0];
            dnum_q[s+1][i] <= {dnum_q[s][i][63:0], 1'b0};
          end
        end
        dv_q[s+1] <= dv_q[s]; dn_q[s+1] <= dn_q[s]; dz_q[s+1] <= dz_q[s];
      end
    end
  end
  // quotient < 2^32 when upper 33 bits of the numerator are below the divisor
  for (genvar i = 0; i < 3; i++) begin : g_out
    logic [31:0] q;
    assign q = dnum_q[DivSteps][i][31:0];
    assign u_o[i] = dn_q[DivSteps][i] ? -$signed(q) : $signed(q);
  end
  assign zero_o = dz_q[DivSteps];

  logic unused;
  assign unused = rst_ni;
endmodule
